### src/heater_profile_pwm_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// heater profile pwm sequencer assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HEATER_PROFILE_PWM_SEQUENCER_TOP_MACROS_SVH
`define HEATER_PROFILE_PWM_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define HPPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpps check failed");

// next-cycle implication
`define HPPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpps check failed");

`endif

### src/hpps_pkg.sv
// ----------------------------------------------------------------------------
// hpps_pkg
// shared types and constants of the heater profile pwm sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package hpps_pkg;

  localparam int ProfileSteps = 10;
  localparam int StepW        = 4;
  localparam int CountW       = 20;
  localparam int TallyW       = 16;
  localparam int SecW         = 16;
  localparam int CheckW       = 8;
  localparam int TempW        = 10;
  localparam int DutyW        = 7;
  localparam int AdcW         = 12;
  localparam int CfgDataW     = 20;
  localparam int ProdW        = 28;

  localparam logic [StepW-1:0] StepCount = StepW'(ProfileSteps);
  localparam logic [DutyW-1:0] DutyFull  = 7'd100;

  localparam logic [CountW-1:0] PeriodReset = 20'd24999;
  localparam logic [TallyW-1:0] PpsReset    = 16'd1000;
  localparam logic [CheckW-1:0] SpcReset    = 8'd10;
  localparam logic [TempW-1:0]  DeltaReset  = 10'd10;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_FAIL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_STAB  = 2'd0,
    PH_RUN   = 2'd1,
    PH_DONE  = 2'd2,
    PH_FAULT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_PPS    = 2'd1,
    CFG_SPC    = 2'd2,
    CFG_DELTA  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [AdcW-1:0]  adc_sample;
    logic [StepW-1:0] entry_index;
    logic [DutyW-1:0] entry_duty;
    logic [SecW-1:0]  entry_seconds;
  } in_item_t;

  typedef struct packed {
    logic             heater_on;
    logic             alarm_on;
    logic [1:0]       phase;
    logic [StepW-1:0] step_index;
    logic [DutyW-1:0] duty_now;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] period;
    logic [TallyW-1:0] pps;
    logic [CheckW-1:0] spc;
    logic [TempW-1:0]  delta;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [StepW-1:0]  step;
    logic [DutyW-1:0]  duty;
    logic [CountW-1:0] count;
  } status_t;

  typedef logic [ProfileSteps-1:0][SecW-1:0]  secs_arr_t;
  typedef logic [ProfileSteps-1:0][DutyW-1:0] duty_arr_t;

  function automatic logic [SecW-1:0] secs_at(secs_arr_t arr, logic [StepW-1:0] idx);
    logic [SecW-1:0] r;
    r = '0;
    for (int i = 0; i < ProfileSteps; i++) begin
      if (idx == StepW'(i)) r = r | arr[i];
    end
    return r;
  endfunction

  function automatic logic [DutyW-1:0] duty_at(duty_arr_t arr, logic [StepW-1:0] idx);
    logic [DutyW-1:0] r;
    r = '0;
    for (int i = 0; i < ProfileSteps; i++) begin
      if (idx == StepW'(i)) r = r | arr[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/hpps_cfg.sv
// ----------------------------------------------------------------------------
// hpps_cfg
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module hpps_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [hpps_pkg::CfgDataW-1:0] cfg_data_i,
  output hpps_pkg::cfg_t                    cfg_o
);
  import hpps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PERIOD: cfg_d.period = cfg_data_i[CountW-1:0];
        CFG_PPS:    cfg_d.pps    = cfg_data_i[TallyW-1:0];
        CFG_SPC:    cfg_d.spc    = cfg_data_i[CheckW-1:0];
        CFG_DELTA:  cfg_d.delta  = cfg_data_i[TempW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PeriodReset;
      cfg_q.pps    <= PpsReset;
      cfg_q.spc    <= SpcReset;
      cfg_q.delta  <= DeltaReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/hpps_ctrl.sv
// ----------------------------------------------------------------------------
// hpps_ctrl
// timing counters, phase sequencing and profile store, one item per cycle while fire_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module hpps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire hpps_pkg::in_item_t item_i,
  input  wire hpps_pkg::cfg_t     cfg_i,
  output hpps_pkg::status_t  status_o
);
  import hpps_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic [SecW-1:0]   es_q, es_d;
  logic [CheckW-1:0] ct_q, ct_d;
  phase_e            mode_q, mode_d;
  logic              await_q, await_d;
  logic [TempW-1:0]  prev_q, prev_d;
  logic [StepW-1:0]  step_q, step_d;
  duty_arr_t         duty_q, duty_d;
  secs_arr_t         secs_q, secs_d;

  logic [CountW-1:0] cnt_inc;
  logic [TallyW-1:0] tally_inc;
  logic [TempW-1:0]  temp;
  logic [TempW-1:0]  diff;
  logic [DutyW-1:0]  duty_sat;
  logic [DutyW-1:0]  duty_now;

  always_comb begin
    cnt_d     = cnt_q;
    tally_d   = tally_q;
    es_d      = es_q;
    ct_d      = ct_q;
    mode_d    = mode_q;
    await_d   = await_q;
    prev_d    = prev_q;
    step_d    = step_q;
    duty_d    = duty_q;
    secs_d    = secs_q;
    cnt_inc   = cnt_q + 20'd1;
    tally_inc = tally_q + 16'd1;
    temp      = item_i.adc_sample[AdcW-1:2];
    diff      = (temp > prev_q) ? (temp - prev_q) : (prev_q - temp);
    duty_sat  = (item_i.entry_duty > DutyFull) ? DutyFull : item_i.entry_duty;
    if (fire_i) begin
      case (item_i.op)
        OP_TICK: begin
          if (mode_q == PH_STAB || mode_q == PH_RUN) begin
            if (cnt_inc <= cfg_i.period && cnt_inc != '0) begin
              cnt_d = cnt_inc;
            end else begin
              cnt_d = '0;
              if (tally_inc < cfg_i.pps) begin
                tally_d = tally_inc;
              end else begin
                tally_d = '0;
                es_d    = es_q + 16'd1;
                ct_d    = ct_q + 8'd1;
                if (mode_q == PH_RUN && es_d >= secs_at(secs_q, step_q)) begin
                  es_d   = '0;
                  step_d = step_q + 4'd1;
                  if (step_d >= StepCount || secs_at(secs_q, step_d) == '0) begin
                    mode_d = PH_DONE;
                  end
                end
                if (ct_d >= cfg_i.spc) begin
                  ct_d = '0;
                  if (mode_q == PH_STAB) begin
                    if (await_q) begin
                      await_d = 1'b0;
                    end else if (diff < cfg_i.delta) begin
                      mode_d = PH_RUN;
                      es_d   = '0;
                      step_d = '0;
                      if (secs_q[0] == '0) mode_d = PH_DONE;
                    end
                    prev_d = temp;
                  end
                end
              end
            end
          end
        end
        OP_LOAD: begin
          if (mode_q != PH_FAULT) begin
            for (int i = 0; i < ProfileSteps; i++) begin
              if (item_i.entry_index == StepW'(i)) begin
                duty_d[i] = duty_sat;
                secs_d[i] = item_i.entry_seconds;
              end
            end
          end
        end
        OP_FAIL: mode_d = PH_FAULT;
        default: mode_d = mode_q;
      endcase
    end
  end

  always_comb begin
    if (mode_d == PH_RUN && step_d < StepCount) begin
      duty_now = duty_at(duty_d, step_d);
    end else begin
      duty_now = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      tally_q <= '0;
      es_q    <= '0;
      ct_q    <= '0;
      mode_q  <= PH_STAB;
      await_q <= 1'b1;
      prev_q  <= '0;
      step_q  <= '0;
      duty_q  <= '0;
      secs_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      tally_q <= tally_d;
      es_q    <= es_d;
      ct_q    <= ct_d;
      mode_q  <= mode_d;
      await_q <= await_d;
      prev_q  <= prev_d;
      step_q  <= step_d;
      duty_q  <= duty_d;
      secs_q  <= secs_d;
    end
  end

  assign status_o.phase = mode_d;
  assign status_o.step  = step_d;
  assign status_o.duty  = duty_now;
  assign status_o.count = cnt_d;

endmodule

`default_nettype wire

### src/hpps_pwm.sv
// ----------------------------------------------------------------------------
// hpps_pwm
// heater level from period count and duty, compared without a divider
// ----------------------------------------------------------------------------
`default_nettype none

module hpps_pwm (
  input  wire hpps_pkg::status_t           status_i,
  input  wire logic [hpps_pkg::CountW-1:0] period_i,
  output logic                           heater_o
);
  import hpps_pkg::*;

  logic [CountW:0]  cnt_p1;
  logic [CountW:0]  per_p1;
  logic [ProdW-1:0] lhs;
  logic [ProdW-1:0] rhs;

  // count < floor(len * duty / 100) is the same as 100 * (count + 1) <= len * duty
  assign cnt_p1 = {1'b0, status_i.count} + 21'd1;
  assign per_p1 = {1'b0, period_i} + 21'd1;
  assign lhs    = ProdW'(cnt_p1) * ProdW'(DutyFull);
  assign rhs    = ProdW'(per_p1) * ProdW'(status_i.duty);

  always_comb begin
    if (status_i.duty == '0) begin
      heater_o = 1'b0;
    end else if (status_i.duty >= DutyFull) begin
      heater_o = 1'b1;
    end else begin
      heater_o = (lhs <= rhs);
    end
  end

endmodule

`default_nettype wire

### src/heater_profile_pwm_sequencer_top.sv
// ----------------------------------------------------------------------------
// heater_profile_pwm_sequencer_top
// ramp and soak heater controller with pwm drive and power-fail latch
// ----------------------------------------------------------------------------
// Items arrive on the in channel (in_valid_i, in_stall_o, in_item_i): a
// clock tick, a profile entry load or a power-fail event. Each item gives
// exactly one result on the out channel (out_valid_o, out_stall_i,
// out_item_o) with the heater level, alarm, phase, step and applied duty.
// An accepted item lands in an input register; once the output register can
// advance, the whole update is done and the result is written to the output
// register, where it is held until it is taken. One item per cycle is
// sustained while out_stall_i is low; the rate is set by the single state
// update per cycle.
// A stalled result holds in the output register while one more item waits
// in the input register; in_stall_o rises only when both are full.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered and
// are to be made only while no item is in flight; the block does not enforce it.
// Reset clears all counters, the profile store and the valid flags of both
// registers, restores the default configuration and starts in the stabilising phase.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heater_profile_pwm_sequencer_top_macros.svh"

module heater_profile_pwm_sequencer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire hpps_pkg::in_item_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output hpps_pkg::out_item_t                out_item_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [hpps_pkg::CfgDataW-1:0] cfg_data_i
);
  import hpps_pkg::*;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      advance;
  logic      fire;
  logic      in_accept;
  logic      heater;
  logic      out_fault;
  cfg_t      cfg;
  status_t   status;

  assign advance   = !out_valid_q || !out_stall_i;
  assign fire      = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_item_d.heater_on  = heater;
    out_item_d.alarm_on   = (status.phase == PH_FAULT);
    out_item_d.phase      = status.phase;
    out_item_d.step_index = status.step;
    out_item_d.duty_now   = status.duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_item_q <= in_item_i;
    if (fire) out_item_q <= out_item_d;
  end

  hpps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hpps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .status_o (status)
  );

  hpps_pwm u_pwm (
    .status_i (status),
    .period_i (cfg.period),
    .heater_o (heater)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_fault   = (out_item_o.phase == PH_FAULT);

  `HPPS_ASSERT_IMP(a_alarm_fault, out_valid_o, out_item_o.alarm_on == out_fault)
  `HPPS_ASSERT_IMP(a_heater_run, out_valid_o && out_item_o.phase != PH_RUN, !out_item_o.heater_on)
  `HPPS_ASSERT_NXT(a_fault_latch, out_valid_o && out_fault, !out_valid_o || out_fault)
  `HPPS_ASSERT_IMP(a_stall_full, in_stall_o, in_valid_q && out_valid_q)

endmodule

`default_nettype wire
